>>> hdl/rsls_pkg.sv
package rsls_pkg;

    // Header constants
    localparam logic [31:0] HDR_MAGIC   = 32'hFA24_C001;
    localparam logic [7:0]  FLAG_VALID  = 8'h02;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL     = 32'hFFFF_FFFF;
    localparam logic [31:0] SERIAL_HALF = 32'h8000_0000;
    localparam logic [15:0] HDR_BYTES   = 16'd32;

    // Region size limit and CRC schedule
    localparam int MAX_SLOTS  = 256;
    localparam int CRC_WORDS  = 8;
    localparam int CNT_W      = $clog2(CRC_WORDS);

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LAYOUT     = 3'd0,
        CFG_TYPE       = 3'd1,
        CFG_SCHEMA     = 3'd2,
        CFG_SLOT_SIZE  = 3'd3,
        CFG_SLOT_COUNT = 3'd4
    } rsls_cfg_idx_t;

    typedef struct packed {
        logic        read_ok;
        logic [31:0] magic_word;
        logic [15:0] hdr_layout;
        logic [15:0] hdr_type;
        logic [15:0] hdr_schema;
        logic [7:0]  hdr_flags;
        logic [31:0] sequence_req;
        logic [15:0] payload_length;
        logic [31:0] stored_header_crc;
        logic [31:0] payload_crc;
    } rsls_in_t;

    typedef struct packed {
        logic        status;
        logic [8:0]  valid_slots;
        logic [7:0]  latest_slot;
        logic [31:0] latest_sequence;
    } rsls_out_t;

    // Checker settings seen by the front end
    typedef struct packed {
        logic [15:0] layout_version;
        logic [15:0] record_type;
        logic [15:0] schema_version;
        logic [15:0] slot_size;
    } rsls_cfg_t;

    // One classified slot, front to back
    typedef struct packed {
        logic        fail;
        logic        ok;
        logic [31:0] seq;
    } rsls_rec_t;

    typedef enum logic [1:0] {
        FR_IDLE = 2'd0,
        FR_CRC  = 2'd1,
        FR_PUSH = 2'd2
    } rsls_front_state_t;

    // Advance a reflected CRC-32 over one little-endian 32-bit word that has
    // already been folded into the register; synthesis flattens it to an
    // XOR network.
    function automatic logic [31:0] crc32_word(input logic [31:0] c_in);
        logic [31:0] c;
        c = c_in;
        for (int k = 0; k < 32; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/rsls_front.sv
module rsls_front
    import rsls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rsls_cfg_t cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  rsls_in_t  in_data,
    output logic      push_valid,
    input  logic      push_ready,
    output rsls_rec_t push_data
);

    rsls_front_state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       crc_reg, crc_next;
    logic [32*CRC_WORDS-1:0] sh_reg, sh_next;
    logic [31:0]       seq_reg, seq_next;
    logic [31:0]       hcrc_reg, hcrc_next;
    logic              fail_reg, fail_next;
    logic              ok_reg, ok_next;

    logic [15:0] cap;
    logic        pre_ok;
    logic        accept;

    // Classify the field checks of an incoming header
    always_comb
    begin
        cap = (cfg.slot_size > HDR_BYTES) ? (cfg.slot_size - HDR_BYTES) : 16'd0;
        pre_ok = (in_data.magic_word == HDR_MAGIC)
              && (in_data.hdr_flags == FLAG_VALID)
              && (in_data.hdr_layout == cfg.layout_version)
              && (in_data.hdr_type == cfg.record_type)
              && (in_data.hdr_schema == cfg.schema_version)
              && (in_data.payload_length <= cap);
    end

    assign in_ready   = (state_reg == FR_IDLE) || ((state_reg == FR_PUSH) && push_ready);
    assign accept     = in_valid && in_ready;
    assign push_valid = (state_reg == FR_PUSH);

    always_comb
    begin
        push_data.fail = fail_reg;
        push_data.ok   = ok_reg && ((crc_reg ^ CRC_ALL) == hcrc_reg);
        push_data.seq  = seq_reg;
    end

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the header and CRC working registers
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        crc_reg  <= crc_next;
        sh_reg   <= sh_next;
        seq_reg  <= seq_next;
        hcrc_reg <= hcrc_next;
        fail_reg <= fail_next;
        ok_reg   <= ok_next;
    end

    // Load a header, walk the CRC one word a cycle, then hand the slot on
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        sh_next    = sh_reg;
        seq_next   = seq_reg;
        hcrc_next  = hcrc_reg;
        fail_next  = fail_reg;
        ok_next    = ok_reg;

        unique case (state_reg)
            FR_IDLE, FR_PUSH:
            begin
                if ((state_reg == FR_PUSH) && push_ready)
                begin
                    state_next = FR_IDLE;
                end
                if (accept)
                begin
                    cnt_next  = '0;
                    crc_next  = CRC_ALL;
                    sh_next   = {32'd0,
                                 in_data.payload_crc,
                                 32'd0,
                                 HDR_BYTES, in_data.payload_length,
                                 in_data.sequence_req,
                                 8'd0, in_data.hdr_flags, in_data.hdr_schema,
                                 in_data.hdr_type, in_data.hdr_layout,
                                 in_data.magic_word};
                    seq_next  = in_data.sequence_req;
                    hcrc_next = in_data.stored_header_crc;
                    fail_next = !in_data.read_ok;
                    ok_next   = pre_ok;
                    state_next = (in_data.read_ok && pre_ok) ? FR_CRC : FR_PUSH;
                end
            end
            FR_CRC:
            begin
                crc_next = crc32_word(crc_reg ^ sh_reg[31:0]);
                sh_next  = sh_reg >> 32;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CRC_WORDS - 1))
                begin
                    state_next = FR_PUSH;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/rsls_queue.sv
module rsls_queue
    import rsls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  rsls_rec_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output rsls_rec_t pop_data
);

    rsls_rec_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store a transfer into the slot under the write pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

>>> hdl/rsls_back.sv
module rsls_back
    import rsls_pkg::*;
#(
    parameter int SLOT_LIMIT = MAX_SLOTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [8:0] slot_count,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  rsls_rec_t pop_data,
    output logic      out_valid,
    input  logic      out_ready,
    output rsls_out_t out_data
);

    localparam logic [8:0] LIMIT_CAP = 9'((SLOT_LIMIT < 256) ? SLOT_LIMIT : 256);

    logic [8:0]  seen_reg, seen_next;
    logic [8:0]  vcnt_reg, vcnt_next;
    logic [31:0] best_seq_reg, best_seq_next;
    logic [7:0]  best_slot_reg, best_slot_next;
    logic        res_valid_reg, res_valid_next;
    rsls_out_t   res_reg, res_next;

    logic [8:0]  limit;
    logic [8:0]  seen_inc;
    logic [8:0]  vcnt_inc;
    logic [31:0] seq_diff;
    logic        newer;
    logic        take;

    assign pop_ready = !res_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // Fold one classified slot into the scan and emit at its end
    always_comb
    begin
        if (slot_count == 9'd0)
        begin
            limit = 9'd1;
        end
        else if (slot_count > LIMIT_CAP)
        begin
            limit = LIMIT_CAP;
        end
        else
        begin
            limit = slot_count;
        end

        seen_inc = seen_reg + 9'd1;
        vcnt_inc = vcnt_reg + 9'd1;
        seq_diff = pop_data.seq - best_seq_reg;
        newer    = (pop_data.seq != best_seq_reg) && (seq_diff < SERIAL_HALF);

        seen_next      = seen_reg;
        vcnt_next      = vcnt_reg;
        best_seq_next  = best_seq_reg;
        best_slot_next = best_slot_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !out_ready;

        if (take)
        begin
            if (pop_data.fail)
            begin
                res_next.status          = 1'b1;
                res_next.valid_slots     = vcnt_reg;
                res_next.latest_slot     = best_slot_reg;
                res_next.latest_sequence = best_seq_reg;
                res_valid_next = 1'b1;
                seen_next      = '0;
                vcnt_next      = '0;
                best_seq_next  = '0;
                best_slot_next = '0;
            end
            else
            begin
                if (pop_data.ok)
                begin
                    vcnt_next = vcnt_inc;
                    if ((vcnt_inc == 9'd1) || newer)
                    begin
                        best_seq_next  = pop_data.seq;
                        best_slot_next = seen_reg[7:0];
                    end
                end
                seen_next = seen_inc;
                if (seen_inc >= limit)
                begin
                    res_next.status          = 1'b0;
                    res_next.valid_slots     = vcnt_next;
                    res_next.latest_slot     = best_slot_next;
                    res_next.latest_sequence = best_seq_next;
                    res_valid_next = 1'b1;
                    seen_next      = '0;
                    vcnt_next      = '0;
                    best_seq_next  = '0;
                    best_slot_next = '0;
                end
            end
        end
    end

    // Hold scan state and the result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            vcnt_reg      <= '0;
            best_seq_reg  <= '0;
            best_slot_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            vcnt_reg      <= vcnt_next;
            best_seq_reg  <= best_seq_next;
            best_slot_reg <= best_slot_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_vcnt_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= seen_reg)
        else $error("valid count exceeds slots seen");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= 9'd255)
        else $error("slot counter ran past the ring");

    a_empty_best: assert property (@(posedge clk) disable iff (!rst_n)
        (vcnt_reg == 9'd0) |-> ((best_seq_reg == 32'd0) && (best_slot_reg == 8'd0)))
        else $error("newest slot set with no valid header");

endmodule

>>> hdl/record_slot_latest_scanner.sv
// Record slot scanner: checks the slot headers of one record region and
// reports how many are valid and which slot holds the newest sequence.
// Channels: in (valid/ready, one slot header per transfer, in slot order)
// and out (valid/ready, one scan summary). Configuration is a plain write
// port (cfg_we, cfg_index, cfg_data); the user must write it only while
// the block is idle, which the block itself does not enforce. A header
// that passes the field checks runs its CRC-32 one 32-bit word per cycle
// over eight words, and no new header is taken until that CRC is done; a
// header that fails a field check or a read skips the CRC. The last
// header's result then passes through the front end's hand-off register,
// the queue and the output register to form the summary; a failed read
// ends the scan at once with status 1.
// A two-entry queue separates the header checker from the scan tracker,
// and the summary sits in an output register: while the receiver stalls
// the front end keeps taking headers until the queue fills.
// Reset restores the default configuration and starts an empty scan;
// it takes effect at once.
module record_slot_latest_scanner
    import rsls_pkg::*;
#(
    parameter int SLOT_LIMIT = MAX_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  rsls_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rsls_out_t   out_data
);

    rsls_cfg_t  cfg_reg;
    logic [8:0] slot_count_reg;

    logic      f_push_valid, f_push_ready;
    rsls_rec_t f_push_data;
    logic      q_pop_valid, q_pop_ready;
    rsls_rec_t q_pop_data;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layout_version <= 16'd1;
            cfg_reg.record_type    <= 16'd1;
            cfg_reg.schema_version <= 16'd1;
            cfg_reg.slot_size      <= 16'd64;
            slot_count_reg         <= 9'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LAYOUT:     cfg_reg.layout_version <= cfg_data;
                CFG_TYPE:       cfg_reg.record_type    <= cfg_data;
                CFG_SCHEMA:     cfg_reg.schema_version <= cfg_data;
                CFG_SLOT_SIZE:  cfg_reg.slot_size      <= cfg_data;
                CFG_SLOT_COUNT: slot_count_reg         <= cfg_data[8:0];
                default:        ;
            endcase
        end
    end

    rsls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (f_push_data)
    );

    rsls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (f_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    rsls_back #(
        .SLOT_LIMIT (SLOT_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_count (slot_count_reg),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
